// File: rtl/kmd_pkg.sv
// shared types, constants and helpers for the key matrix debounce block
package kmd_pkg;

  localparam int TIME_W    = 32;
  localparam int THRESH_W  = 31;
  localparam int KEY_NUM_W = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [THRESH_W-1:0] PRESS_DEB_RST   = 31'd20000;
  localparam logic [THRESH_W-1:0] RELEASE_DEB_RST = 31'd20000;
  localparam logic [THRESH_W-1:0] LONG_PRESS_RST  = 31'd1000000;

  typedef enum logic [1:0] {
    PH_IDLE        = 2'd0,
    PH_DEB_PRESS   = 2'd1,
    PH_PRESSED     = 2'd2,
    PH_DEB_RELEASE = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_LONG    = 2'd1,
    EV_RELEASE = 2'd2
  } event_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRESS_DEB   = 2'd0,
    CFG_RELEASE_DEB = 2'd1,
    CFG_LONG_PRESS  = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [THRESH_W-1:0] press_deb;
    logic [THRESH_W-1:0] release_deb;
    logic [THRESH_W-1:0] long_hold;
  } thresh_t;

  typedef struct packed {
    logic        fire;
    event_kind_t kind;
  } key_event_t;

  // modular elapsed time, negative never reaches
  function automatic logic reached(input logic [TIME_W-1:0]   now,
                                   input logic [TIME_W-1:0]   stamp,
                                   input logic [THRESH_W-1:0] limit);
    logic [TIME_W-1:0] d;
    d = now - stamp;
    return !d[TIME_W-1] && (d[THRESH_W-1:0] >= limit);
  endfunction

endpackage

// File: rtl/key_matrix_debounce_long_press_core.sv
// top level of the key matrix debounce and long press detector
// One sample beat is taken per clock (busy stays low). Its event, if any, shows on
// out_valid for a single cycle; the beat is held in the sample register, and the
// rate is set by the read-modify-write of the addressed key's state, done between
// the sample register and the result register that drives out_valid.
// The receiver cannot stall: each strobe must be captured when it shows. Keys are
// numbered 0 for the encoder switch and 1 + row*COLS + col for the matrix; out-of-range
// samples give no event.
module key_matrix_debounce_long_press_core #(
  parameter int ROWS = 4,
  parameter int COLS = 3
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_key_row,
  input  logic [1:0]                     in_key_col,
  input  logic                           in_is_switch,
  input  logic                           in_pressed,
  input  logic [kmd_pkg::TIME_W-1:0]     in_now_us,
  output logic                           out_valid,
  output logic [kmd_pkg::KEY_NUM_W-1:0]  out_key_number,
  output logic [1:0]                     out_event_kind,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [kmd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kmd_pkg::THRESH_W-1:0]   cfg_wdata
);

  localparam int KEYS = 1 + ROWS * COLS;
  localparam int KW   = $clog2(KEYS);

  kmd_pkg::thresh_t             thresh;
  kmd_pkg::key_event_t          evt;

  logic                         hit;
  logic [KW-1:0]                key_idx_c;

  logic                         item_vld_r;
  logic [KW-1:0]                key_idx_r;
  logic                         pressed_r;
  logic [kmd_pkg::TIME_W-1:0]   now_r;

  logic                         out_valid_r;
  logic [kmd_pkg::KEY_NUM_W-1:0] out_key_number_r;
  kmd_pkg::event_kind_t         out_event_kind_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  kmd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_wdata),
    .thresh  (thresh)
  );

  assign hit = in_is_switch ||
               ((int'(in_key_row) < ROWS) && (int'(in_key_col) < COLS));
  assign key_idx_c = in_is_switch ? '0 :
                     KW'(int'(in_key_row) * COLS + int'(in_key_col) + 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else begin
      item_vld_r <= start && !busy && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      key_idx_r <= key_idx_c;
      pressed_r <= in_pressed;
      now_r     <= in_now_us;
    end
  end

  kmd_key_state #(
    .KEYS (KEYS),
    .KW   (KW)
  ) u_state (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_vld (item_vld_r),
    .key_idx  (key_idx_r),
    .pressed  (pressed_r),
    .now      (now_r),
    .thresh   (thresh),
    .evt      (evt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= evt.fire;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.fire) begin
      out_key_number_r <= kmd_pkg::KEY_NUM_W'(key_idx_r);
      out_event_kind_r <= evt.kind;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_key_number = out_key_number_r;
  assign out_event_kind = out_event_kind_r;

endmodule

// File: rtl/kmd_cfg_regs.sv
// configuration register file holding the debounce and long press times
module kmd_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [kmd_pkg::CFG_IDX_W-1:0] wr_idx,
  input  logic [kmd_pkg::THRESH_W-1:0]  wr_data,
  output kmd_pkg::thresh_t              thresh
);

  kmd_pkg::thresh_t thresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r.press_deb   <= kmd_pkg::PRESS_DEB_RST;
      thresh_r.release_deb <= kmd_pkg::RELEASE_DEB_RST;
      thresh_r.long_hold   <= kmd_pkg::LONG_PRESS_RST;
    end else if (wr_en) begin
      unique case (kmd_pkg::cfg_index_t'(wr_idx))
        kmd_pkg::CFG_PRESS_DEB:   thresh_r.press_deb   <= wr_data;
        kmd_pkg::CFG_RELEASE_DEB: thresh_r.release_deb <= wr_data;
        kmd_pkg::CFG_LONG_PRESS:  thresh_r.long_hold   <= wr_data;
        default: ;
      endcase
    end
  end

  assign thresh = thresh_r;

endmodule

// File: rtl/kmd_key_state.sv
// per-key phase storage and the read-modify-write debounce update for the addressed key
module kmd_key_state #(
  parameter int KEYS = 13,
  parameter int KW   = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        item_vld,
  input  logic [KW-1:0]               key_idx,
  input  logic                        pressed,
  input  logic [kmd_pkg::TIME_W-1:0]  now,
  input  kmd_pkg::thresh_t            thresh,
  output kmd_pkg::key_event_t         evt
);

  kmd_pkg::phase_t             phase_r      [KEYS];
  logic [kmd_pkg::TIME_W-1:0]  chg_time_r   [KEYS];
  logic [kmd_pkg::TIME_W-1:0]  start_time_r [KEYS];
  logic                        long_done_r  [KEYS];

  kmd_pkg::phase_t             cur_phase;
  logic [kmd_pkg::TIME_W-1:0]  cur_chg;
  logic [kmd_pkg::TIME_W-1:0]  cur_start;
  logic                        cur_long;
  kmd_pkg::phase_t             phase_nxt;
  logic                        long_done_nxt;
  logic                        wr_chg;
  logic                        wr_start;
  logic                        fire;
  kmd_pkg::event_kind_t        kind;

  assign cur_phase = phase_r[key_idx];
  assign cur_chg   = chg_time_r[key_idx];
  assign cur_start = start_time_r[key_idx];
  assign cur_long  = long_done_r[key_idx];

  always_comb begin
    phase_nxt     = cur_phase;
    long_done_nxt = cur_long;
    wr_chg        = 1'b0;
    wr_start      = 1'b0;
    fire          = 1'b0;
    kind          = kmd_pkg::EV_PRESS;
    unique case (cur_phase)
      kmd_pkg::PH_IDLE: begin
        if (pressed) begin
          phase_nxt = kmd_pkg::PH_DEB_PRESS;
          wr_chg    = 1'b1;
        end
      end
      kmd_pkg::PH_DEB_PRESS: begin
        if (!pressed) begin
          phase_nxt = kmd_pkg::PH_IDLE;
        end else if (kmd_pkg::reached(now, cur_chg, thresh.press_deb)) begin
          phase_nxt     = kmd_pkg::PH_PRESSED;
          wr_start      = 1'b1;
          long_done_nxt = 1'b0;
          fire          = 1'b1;
          kind          = kmd_pkg::EV_PRESS;
        end
      end
      kmd_pkg::PH_PRESSED: begin
        if (!pressed) begin
          phase_nxt = kmd_pkg::PH_DEB_RELEASE;
          wr_chg    = 1'b1;
        end else if (!cur_long && kmd_pkg::reached(now, cur_start, thresh.long_hold)) begin
          long_done_nxt = 1'b1;
          fire          = 1'b1;
          kind          = kmd_pkg::EV_LONG;
        end
      end
      kmd_pkg::PH_DEB_RELEASE: begin
        if (pressed) begin
          phase_nxt = kmd_pkg::PH_PRESSED;
        end else if (kmd_pkg::reached(now, cur_chg, thresh.release_deb)) begin
          phase_nxt = kmd_pkg::PH_IDLE;
          fire      = 1'b1;
          kind      = kmd_pkg::EV_RELEASE;
        end
      end
      default: ;
    endcase
  end

  assign evt.fire = item_vld && fire;
  assign evt.kind = kind;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEYS; i++) begin
        phase_r[i] <= kmd_pkg::PH_IDLE;
      end
    end else if (item_vld) begin
      phase_r[key_idx] <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_vld) begin
      long_done_r[key_idx] <= long_done_nxt;
      if (wr_chg) begin
        chg_time_r[key_idx] <= now;
      end
      if (wr_start) begin
        start_time_r[key_idx] <= now;
      end
    end
  end

endmodule

// File: rtl/kmd_checker.sv
// port-level checker for the key matrix debounce core and its bind
module kmd_checker #(
  parameter int ROWS = 4,
  parameter int COLS = 3
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic [1:0]                     in_key_row,
  input logic [1:0]                     in_key_col,
  input logic                           in_is_switch,
  input logic                           in_pressed,
  input logic                           out_valid,
  input logic [1:0]                     out_event_kind
);

  // every event traces back to an accepted beat through the sample and result registers
  a_evt_from_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("event without a beat");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_event_kind <= kmd_pkg::EV_RELEASE))
    else $error("illegal event kind");

  // a low sample can only confirm a release
  a_low_no_press: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_pressed) |->
      ##2 (!out_valid || out_event_kind == kmd_pkg::EV_RELEASE))
    else $error("press event from a low sample");

  // a high sample never confirms a release
  a_high_no_release: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_pressed) |->
      ##2 (!out_valid || out_event_kind != kmd_pkg::EV_RELEASE))
    else $error("release event from a high sample");

  a_out_of_range_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_is_switch &&
     ((int'(in_key_row) >= ROWS) || (int'(in_key_col) >= COLS))) |-> ##2 !out_valid)
    else $error("event for an out-of-range key");

endmodule

bind key_matrix_debounce_long_press_core kmd_checker #(
  .ROWS (ROWS),
  .COLS (COLS)
) u_kmd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_key_row     (in_key_row),
  .in_key_col     (in_key_col),
  .in_is_switch   (in_is_switch),
  .in_pressed     (in_pressed),
  .out_valid      (out_valid),
  .out_event_kind (out_event_kind)
);
